>>> sv/bisc_pkg.sv
package bisc_pkg;

	localparam int MAX_ROWS_DEF  = 256;
	localparam int MAX_COLS_DEF  = 256;
	localparam int FRAC_BITS_DEF = 12;

	localparam int ROW_W     = 12;
	localparam int COL_W     = 12;
	localparam int CH_W      = 8;
	localparam int NCH       = 3;
	localparam int PX_W      = CH_W * NCH;
	localparam int DIM_W     = 9;
	localparam int SCALE_W   = 20;
	localparam int POS_W     = ROW_W + SCALE_W;
	localparam int CFG_IDX_W = 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_REQ  = 1'b1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_SRC_ROWS      = cfg_idx_t'(0);
	localparam cfg_idx_t REG_SRC_COLS      = cfg_idx_t'(1);
	localparam cfg_idx_t REG_INV_SCALE_ROW = cfg_idx_t'(2);
	localparam cfg_idx_t REG_INV_SCALE_COL = cfg_idx_t'(3);

	localparam logic [DIM_W-1:0]   SRC_ROWS_RST  = DIM_W'(256);
	localparam logic [DIM_W-1:0]   SRC_COLS_RST  = DIM_W'(256);
	localparam logic [SCALE_W-1:0] INV_SCALE_RST = SCALE_W'(4096);

	typedef logic [CH_W-1:0] chan_t;
	typedef chan_t [NCH-1:0] pixel_t;

	// neighbor position flags handed from locate to blend
	typedef struct packed {
		logic in_area;
		logic row_odd;
		logic col_odd;
	} loc_flags_t;

endpackage

>>> sv/bilinear_image_scaler_unit.sv
// a request's result is registered in the input, position, bank read, weight, product and output stages in turn
// throughput: one beat per cycle while the output is not stalled, loads and requests alike, set by the four
// parity banks of the frame store that give all four neighbors in one read
// a stall on the output backs up only as far as the first empty stage
// reset clears valids and sets config registers to their defaults
// frame store contents stay undefined until loaded
module bilinear_image_scaler_unit #(
	parameter int MAX_ROWS  = bisc_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = bisc_pkg::MAX_COLS_DEF,
	parameter int FRAC_BITS = bisc_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  bisc_pkg::cfg_idx_t           cfg_index,
	input  logic [bisc_pkg::SCALE_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         operation,
	input  logic [bisc_pkg::ROW_W-1:0]   pixel_row,
	input  logic [bisc_pkg::COL_W-1:0]   pixel_col,
	input  logic [bisc_pkg::CH_W-1:0]    chan0_in,
	input  logic [bisc_pkg::CH_W-1:0]    chan1_in,
	input  logic [bisc_pkg::CH_W-1:0]    chan2_in,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [bisc_pkg::CH_W-1:0]    chan0_out,
	output logic [bisc_pkg::CH_W-1:0]    chan1_out,
	output logic [bisc_pkg::CH_W-1:0]    chan2_out,
	output logic                         inside_res
);

	localparam int RW = (MAX_ROWS > 2) ? $clog2(MAX_ROWS) : 2;
	localparam int CW = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 2;
	localparam int AW = RW + CW - 2;
	localparam logic [bisc_pkg::ROW_W:0] LD_MAXR = (bisc_pkg::ROW_W+1)'(MAX_ROWS);
	localparam logic [bisc_pkg::COL_W:0] LD_MAXC = (bisc_pkg::COL_W+1)'(MAX_COLS);

	logic [bisc_pkg::DIM_W-1:0]   src_rows_q, src_cols_q;
	logic [bisc_pkg::SCALE_W-1:0] inv_scale_row_q, inv_scale_col_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_out_q;
	logic en1, en2, en3, en4, en5, en_out;

	logic                           op_s1, op_s2;
	logic [bisc_pkg::ROW_W-1:0]     row_s1, row_s2;
	logic [bisc_pkg::COL_W-1:0]     col_s1, col_s2;
	bisc_pkg::pixel_t               pix_s1, pix_s2;

	bisc_pkg::loc_flags_t loc_flags;
	logic [FRAC_BITS-1:0] frac_r, frac_c;
	logic [AW-1:0]        rd_addr [4];
	bisc_pkg::pixel_t     rd_data [4];

	logic          wr_en;
	logic [1:0]    wr_bank;
	logic [AW-1:0] wr_addr;

	bisc_pkg::pixel_t res_px, px_q;
	logic             res_inside, inside_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rows_q      <= bisc_pkg::SRC_ROWS_RST;
			src_cols_q      <= bisc_pkg::SRC_COLS_RST;
			inv_scale_row_q <= bisc_pkg::INV_SCALE_RST;
			inv_scale_col_q <= bisc_pkg::INV_SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bisc_pkg::REG_SRC_ROWS: begin
					src_rows_q <= cfg_data[bisc_pkg::DIM_W-1:0];
				end
				bisc_pkg::REG_SRC_COLS: begin
					src_cols_q <= cfg_data[bisc_pkg::DIM_W-1:0];
				end
				bisc_pkg::REG_INV_SCALE_ROW: begin
					inv_scale_row_q <= cfg_data;
				end
				bisc_pkg::REG_INV_SCALE_COL: begin
					inv_scale_col_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// each stage moves when it is empty or the next one moves
	assign en_out   = !v_out_q || !out_stall;
	assign en5      = !v_s5 || en_out;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2 && (op_s2 == bisc_pkg::OP_REQ);
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en_out) v_out_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1  <= operation;
			row_s1 <= pixel_row;
			col_s1 <= pixel_col;
			pix_s1 <= {chan2_in, chan1_in, chan0_in};
		end
		if (en2) begin
			op_s2  <= op_s1;
			row_s2 <= row_s1;
			col_s2 <= col_s1;
			pix_s2 <= pix_s1;
		end
		if (en_out) begin
			px_q     <= res_px;
			inside_q <= res_inside;
		end
	end

	bisc_locate #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS),
		.FRAC_BITS(FRAC_BITS),
		.RW       (RW),
		.CW       (CW)
	) u_locate (
		.clk          (clk),
		.en           (en2),
		.row_s1       (row_s1),
		.col_s1       (col_s1),
		.src_rows     (src_rows_q),
		.src_cols     (src_cols_q),
		.inv_scale_row(inv_scale_row_q),
		.inv_scale_col(inv_scale_col_q),
		.flags        (loc_flags),
		.frac_r       (frac_r),
		.frac_c       (frac_c),
		.rd_addr      (rd_addr)
	);

	// load beat writes as it leaves the address stage
	assign wr_en = en3 && v_s2 && (op_s2 == bisc_pkg::OP_LOAD)
		&& ({1'b0, row_s2} < LD_MAXR) && ({1'b0, col_s2} < LD_MAXC);
	assign wr_bank = {row_s2[0], col_s2[0]};
	assign wr_addr = {row_s2[RW-1:1], col_s2[CW-1:1]};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		bisc_bank #(
			.AW(AW),
			.DW(bisc_pkg::PX_W)
		) u_bank (
			.clk    (clk),
			.wr_en  (wr_en && (wr_bank == 2'(b))),
			.wr_addr(wr_addr),
			.wr_data(pix_s2),
			.rd_en  (en3),
			.rd_addr(rd_addr[b]),
			.rd_data(rd_data[b])
		);
	end

	bisc_blend #(
		.FRAC_BITS(FRAC_BITS)
	) u_blend (
		.clk       (clk),
		.en3       (en3),
		.en4       (en4),
		.en5       (en5),
		.flags     (loc_flags),
		.frac_r    (frac_r),
		.frac_c    (frac_c),
		.bank_px   (rd_data),
		.res_px    (res_px),
		.res_inside(res_inside)
	);

	assign out_valid  = v_out_q;
	assign chan0_out  = px_q[0];
	assign chan1_out  = px_q[1];
	assign chan2_out  = px_q[2];
	assign inside_res = inside_q;

endmodule

>>> sv/bisc_bank.sv
module bisc_bank #(
	parameter int AW = 14,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> sv/bisc_locate.sv
module bisc_locate #(
	parameter int MAX_ROWS  = bisc_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS  = bisc_pkg::MAX_COLS_DEF,
	parameter int FRAC_BITS = bisc_pkg::FRAC_BITS_DEF,
	parameter int RW        = 8,
	parameter int CW        = 8
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic [bisc_pkg::ROW_W-1:0]   row_s1,
	input  logic [bisc_pkg::COL_W-1:0]   col_s1,
	input  logic [bisc_pkg::DIM_W-1:0]   src_rows,
	input  logic [bisc_pkg::DIM_W-1:0]   src_cols,
	input  logic [bisc_pkg::SCALE_W-1:0] inv_scale_row,
	input  logic [bisc_pkg::SCALE_W-1:0] inv_scale_col,
	output bisc_pkg::loc_flags_t         flags,
	output logic [FRAC_BITS-1:0]         frac_r,
	output logic [FRAC_BITS-1:0]         frac_c,
	output logic [RW+CW-3:0]             rd_addr [4]
);

	localparam int IRW = bisc_pkg::POS_W - FRAC_BITS;
	localparam logic [IRW:0] MAXR = (IRW+1)'(MAX_ROWS);
	localparam logic [IRW:0] MAXC = (IRW+1)'(MAX_COLS);

	logic [bisc_pkg::POS_W-1:0] pr_s2, pc_s2;
	logic [IRW-1:0] ir, ic;
	logic [IRW:0]   ir_sum, ic_sum, rows_ext, cols_ext, rows_eff, cols_eff;
	logic [RW-1:0]  row_lo;
	logic [CW-1:0]  col_lo;
	logic [RW:0]    re_sum;
	logic [CW:0]    ce_sum;
	logic [RW-2:0]  even_r, odd_r;
	logic [CW-2:0]  even_c, odd_c;

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2 <= bisc_pkg::POS_W'(row_s1) * bisc_pkg::POS_W'(inv_scale_row);
			pc_s2 <= bisc_pkg::POS_W'(col_s1) * bisc_pkg::POS_W'(inv_scale_col);
		end
	end

	assign ir     = pr_s2[bisc_pkg::POS_W-1:FRAC_BITS];
	assign ic     = pc_s2[bisc_pkg::POS_W-1:FRAC_BITS];
	assign frac_r = pr_s2[FRAC_BITS-1:0];
	assign frac_c = pc_s2[FRAC_BITS-1:0];

	assign rows_ext = (IRW+1)'(src_rows);
	assign cols_ext = (IRW+1)'(src_cols);
	assign rows_eff = (rows_ext < MAXR) ? rows_ext : MAXR;
	assign cols_eff = (cols_ext < MAXC) ? cols_ext : MAXC;
	assign ir_sum   = {1'b0, ir} + (IRW+1)'(1);
	assign ic_sum   = {1'b0, ic} + (IRW+1)'(1);

	assign flags.in_area = (ir_sum < rows_eff) && (ic_sum < cols_eff);
	assign flags.row_odd = ir[0];
	assign flags.col_odd = ic[0];

	// even bank holds the even one of the two neighbor rows
	assign row_lo = ir[RW-1:0];
	assign col_lo = ic[CW-1:0];
	assign re_sum = {1'b0, row_lo} + (RW+1)'(row_lo[0]);
	assign ce_sum = {1'b0, col_lo} + (CW+1)'(col_lo[0]);
	assign even_r = re_sum[RW-1:1];
	assign odd_r  = row_lo[RW-1:1];
	assign even_c = ce_sum[CW-1:1];
	assign odd_c  = col_lo[CW-1:1];

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			rd_addr[b] = {(b >= 2) ? odd_r : even_r, ((b & 1) != 0) ? odd_c : even_c};
		end
	end

endmodule

>>> sv/bisc_blend.sv
module bisc_blend #(
	parameter int FRAC_BITS = bisc_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en3,
	input  logic                 en4,
	input  logic                 en5,
	input  bisc_pkg::loc_flags_t flags,
	input  logic [FRAC_BITS-1:0] frac_r,
	input  logic [FRAC_BITS-1:0] frac_c,
	input  bisc_pkg::pixel_t     bank_px [4],
	output bisc_pkg::pixel_t     res_px,
	output logic                 res_inside
);

	localparam int WW  = FRAC_BITS + 1;
	localparam int MW  = 2 * FRAC_BITS + 2;
	localparam int PRW = WW + bisc_pkg::CH_W;
	localparam int SW  = PRW + 2;
	localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	bisc_pkg::loc_flags_t fl_s3;
	logic [FRAC_BITS-1:0] a_s3, b_s3;
	logic [FRAC_BITS:0]   na, nb;
	logic [MW-1:0]        m [4];
	logic [WW-1:0]        w [4];
	bisc_pkg::pixel_t     px [4];
	logic [1:0]           sel [4];

	logic [WW-1:0]        w_s4 [4];
	bisc_pkg::pixel_t     px_s4 [4];
	logic                 ins_s4;

	logic [PRW-1:0]       prod_s5 [4][bisc_pkg::NCH];
	logic                 ins_s5;
	logic [SW-1:0]        sum [bisc_pkg::NCH];

	always_ff @(posedge clk) begin
		if (en3) begin
			fl_s3 <= flags;
			a_s3  <= frac_r;
			b_s3  <= frac_c;
		end
	end

	assign na   = ONE - {1'b0, a_s3};
	assign nb   = ONE - {1'b0, b_s3};
	assign m[0] = MW'(na) * MW'(nb);
	assign m[1] = MW'(a_s3) * MW'(nb);
	assign m[2] = MW'(na) * MW'(b_s3);
	assign m[3] = MW'(a_s3) * MW'(b_s3);

	// bank index is {row parity, col parity}
	assign sel[0] = {fl_s3.row_odd, fl_s3.col_odd};
	assign sel[1] = {~fl_s3.row_odd, fl_s3.col_odd};
	assign sel[2] = {fl_s3.row_odd, ~fl_s3.col_odd};
	assign sel[3] = {~fl_s3.row_odd, ~fl_s3.col_odd};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			w[k]  = m[k][2*FRAC_BITS:FRAC_BITS];
			px[k] = bank_px[sel[k]];
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int k = 0; k < 4; k++) begin
				w_s4[k]  <= w[k];
				px_s4[k] <= px[k];
			end
			ins_s4 <= fl_s3.in_area;
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int k = 0; k < 4; k++) begin
				for (int c = 0; c < bisc_pkg::NCH; c++) begin
					prod_s5[k][c] <= PRW'(w_s4[k]) * PRW'(px_s4[k][c]);
				end
			end
			ins_s5 <= ins_s4;
		end
	end

	always_comb begin
		for (int c = 0; c < bisc_pkg::NCH; c++) begin
			sum[c] = SW'(prod_s5[0][c]) + SW'(prod_s5[1][c])
				+ SW'(prod_s5[2][c]) + SW'(prod_s5[3][c]);
			res_px[c] = ins_s5 ? sum[c][FRAC_BITS+bisc_pkg::CH_W-1:FRAC_BITS] : '0;
		end
	end

	assign res_inside = ins_s5;

endmodule

>>> sv/bisc_checker.sv
module bisc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [bisc_pkg::CH_W-1:0]    chan0_out,
	input logic [bisc_pkg::CH_W-1:0]    chan1_out,
	input logic [bisc_pkg::CH_W-1:0]    chan2_out,
	input logic                         inside_res
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(chan0_out)
			&& $stable(chan1_out) && $stable(chan2_out) && $stable(inside_res))
		else $error("stalled result beat changed");

	// position outside the image gives black
	a_outside_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !inside_res |-> chan0_out == '0 && chan1_out == '0
			&& chan2_out == '0)
		else $error("outside result not black");

	// input backs up only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back pressure");

	// config port never refuses a write
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind bilinear_image_scaler_unit bisc_checker u_bisc_checker (.*);
